// ===== rtl/uart_pkg.sv =====
// Shared types, codes and default sizes for the 8N1 UART with receive FIFO.
package uart_pkg;

  localparam int unsigned UART_FIFO_DEPTH  = 64;
  localparam int unsigned UART_START_EXTRA = 5;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TXT_W     = 17;
  localparam int unsigned FILL_W    = 6;

  // request kinds carried in the input tuser
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RX_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_BIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_STOP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_BIT    = 2'd3;

  typedef enum logic [1:0] {
    RX_IDLE   = 2'd0,
    RX_CENTER = 2'd1,
    RX_DATA   = 2'd2,
    RX_STOP   = 2'd3
  } rx_phase_t;

endpackage

// ===== rtl/uart_8n1_with_rx_fifo_core.sv =====
// Top level: tick-timed 8N1 receiver and transmitter with a receive ring FIFO in RAM.
//
//  channel | dir | handshake         | beat content
//  --------+-----+-------------------+-----------------------------------------------
//  s_*     | in  | s_tvalid/s_tready | request kind, rx line level, byte to send
//  m_*     | out | m_tvalid/m_tready | tx level, read flag and byte, fill, status
//  cfg_*   | in  | cfg_valid/ready   | register index and 16-bit value
//
//  One beat per cycle in each direction; every input beat yields one output beat
//  in the following cycle through the output register. The FIFO RAM is read at the head
//  in the accept cycle and its registered data forms rd_data of that beat.
//  The input stalls only while the output register holds a beat not yet taken.
//  Reset is synchronous; FIFO contents are not cleared, the pointers are.
module uart_8n1_with_rx_fifo_core
  import uart_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = UART_FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // [0] rx_level, [8:1] tx_byte
  input  logic [1:0]           s_tuser,   // [1:0] req_type
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // [0] tx_level, [8:1] rd_data,
                                          // [14:9] fill_count, [15] write_accepted,
                                          // [16] tx_busy
  output logic                 m_tuser,   // [0] rd_valid
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int unsigned AW  = $clog2(FIFO_DEPTH);
  localparam int unsigned FW  = (AW + 1 > FILL_W) ? AW + 1 : FILL_W;
  localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);

  logic [CFG_W-1:0] rx_center_wait, rx_bit_wait, rx_stop_wait, tx_bit_wait;

  rx_phase_t        rx_phase, rx_phase_next;
  logic [CFG_W-1:0] rx_timer, rx_timer_next;
  logic [7:0]       rx_shift, rx_shift_next;
  logic [3:0]       rx_bit_count, rx_bit_count_next;
  logic [AW-1:0]    fifo_head, fifo_head_next, fifo_tail, fifo_tail_next;
  logic [TXT_W-1:0] tx_timer, tx_timer_next;
  logic [7:0]       tx_shift, tx_shift_next;
  logic [3:0]       tx_bit_count, tx_bit_count_next;
  logic             tx_line, tx_line_next;

  logic             out_valid;
  logic             out_rd_valid, out_tx_level, out_accepted, out_busy;
  logic [FILL_W-1:0] out_fill;

  logic             accept;
  logic             push, pop, accepted;
  logic [AW-1:0]    tail_inc, head_inc;
  logic [AW:0]      fill;
  logic [FW-1:0]    fill_wide;
  logic [7:0]       ram_q;
  logic             rx_level;
  logic [7:0]       tx_byte;

  assign rx_level  = s_tdata[0];
  assign tx_byte   = s_tdata[8:1];
  assign s_tready  = !out_valid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign tail_inc = (fifo_tail == PTR_LAST) ? '0 : fifo_tail + 1'b1;
  assign head_inc = (fifo_head == PTR_LAST) ? '0 : fifo_head + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_center_wait <= '0;
      rx_bit_wait    <= '0;
      rx_stop_wait   <= '0;
      tx_bit_wait    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RX_CENTER: rx_center_wait <= cfg_data;
        CFG_RX_BIT:    rx_bit_wait    <= cfg_data;
        CFG_RX_STOP:   rx_stop_wait   <= cfg_data;
        CFG_TX_BIT:    tx_bit_wait    <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_comb begin
    rx_phase_next     = rx_phase;
    rx_timer_next     = rx_timer;
    rx_shift_next     = rx_shift;
    rx_bit_count_next = rx_bit_count;
    fifo_head_next    = fifo_head;
    fifo_tail_next    = fifo_tail;
    tx_timer_next     = tx_timer;
    tx_shift_next     = tx_shift;
    tx_bit_count_next = tx_bit_count;
    tx_line_next      = tx_line;
    push              = 1'b0;
    pop               = 1'b0;
    accepted          = 1'b0;

    case (s_tuser)
      REQ_TICK: begin
        // receiver
        if (rx_phase == RX_IDLE) begin
          if (rx_stop_wait != '0 && !rx_level) begin
            rx_phase_next     = RX_CENTER;
            rx_timer_next     = rx_center_wait;
            rx_shift_next     = '0;
            rx_bit_count_next = '0;
          end
        end else if (rx_timer != '0) begin
          rx_timer_next = rx_timer - 1'b1;
        end else begin
          case (rx_phase)
            RX_CENTER: begin
              rx_phase_next = RX_DATA;
              rx_timer_next = rx_bit_wait;
            end
            RX_DATA: begin
              rx_shift_next = rx_shift | (8'(rx_level) << rx_bit_count[2:0]);
              rx_bit_count_next = rx_bit_count + 1'b1;
              if (rx_bit_count_next >= 4'd8) begin
                rx_phase_next = RX_STOP;
                rx_timer_next = rx_stop_wait;
              end else begin
                rx_timer_next = rx_bit_wait;
              end
            end
            default: begin
              // drop the byte when only the spare slot is left
              if (tail_inc != fifo_head) begin
                push           = 1'b1;
                fifo_tail_next = tail_inc;
              end
              rx_phase_next     = RX_IDLE;
              rx_bit_count_next = '0;
            end
          endcase
        end
        // transmitter
        if (tx_bit_count != '0) begin
          if (tx_timer != '0) begin
            tx_timer_next = tx_timer - 1'b1;
          end else if (tx_bit_count <= 4'd8) begin
            tx_bit_count_next = tx_bit_count + 1'b1;
            tx_line_next      = tx_shift[3'(tx_bit_count - 1'b1)];
            tx_timer_next     = TXT_W'(tx_bit_wait);
          end else if (tx_bit_count == 4'd9) begin
            tx_bit_count_next = 4'd10;
            tx_line_next      = 1'b1;
            tx_timer_next     = TXT_W'(tx_bit_wait);
          end else begin
            tx_bit_count_next = '0;
            tx_line_next      = 1'b1;
            tx_timer_next     = '0;
          end
        end
      end
      REQ_READ: begin
        if (fifo_head != fifo_tail) begin
          pop            = 1'b1;
          fifo_head_next = head_inc;
        end
      end
      REQ_WRITE: begin
        if (tx_bit_wait != '0 && tx_bit_count == '0) begin
          accepted          = 1'b1;
          tx_shift_next     = tx_byte;
          tx_bit_count_next = 4'd1;
          tx_line_next      = 1'b0;
          tx_timer_next     = TXT_W'(tx_bit_wait) + TXT_W'(UART_START_EXTRA);
        end
      end
      default: ;
    endcase
  end

  assign fill = (fifo_tail_next >= fifo_head_next)
              ? {1'b0, fifo_tail_next} - {1'b0, fifo_head_next}
              : {1'b0, fifo_tail_next} + (AW + 1)'(FIFO_DEPTH) - {1'b0, fifo_head_next};
  assign fill_wide = FW'(fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase     <= RX_IDLE;
      rx_timer     <= '0;
      rx_shift     <= '0;
      rx_bit_count <= '0;
      fifo_head    <= '0;
      fifo_tail    <= '0;
      tx_timer     <= '0;
      tx_shift     <= '0;
      tx_bit_count <= '0;
      tx_line      <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        rx_phase     <= rx_phase_next;
        rx_timer     <= rx_timer_next;
        rx_shift     <= rx_shift_next;
        rx_bit_count <= rx_bit_count_next;
        fifo_head    <= fifo_head_next;
        fifo_tail    <= fifo_tail_next;
        tx_timer     <= tx_timer_next;
        tx_shift     <= tx_shift_next;
        tx_bit_count <= tx_bit_count_next;
        tx_line      <= tx_line_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result fields; held while the beat waits
  always_ff @(posedge clk) begin
    if (accept) begin
      out_tx_level <= tx_line_next;
      out_rd_valid <= pop;
      out_fill     <= fill_wide[FILL_W-1:0];
      out_accepted <= accepted;
      out_busy     <= (tx_bit_count_next != '0);
    end
  end

  uart_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (accept && push),
    .waddr (fifo_tail),
    .wdata (rx_shift),
    .re    (accept && pop),
    .raddr (fifo_head),
    .rdata (ram_q)
  );

  assign m_tvalid = out_valid;
  assign m_tuser  = out_rd_valid;
  assign m_tdata  = {7'd0, out_busy, out_accepted, out_fill,
                     (out_rd_valid ? ram_q : 8'd0), out_tx_level};

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (AW + 1)'(FIFO_DEPTH - 1))
    else $error("FIFO fill beyond depth minus one");

  a_tx_idle_high: assert property (@(posedge clk) disable iff (rst)
    (tx_bit_count == '0) |-> tx_line)
    else $error("TX line low while transmitter idle");

  a_rx_count: assert property (@(posedge clk) disable iff (rst)
    (rx_phase == RX_DATA) |-> (rx_bit_count < 4'd8))
    else $error("RX bit count out of range in data phase");

  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    (accept && pop) |=> (m_tvalid && m_tuser))
    else $error("popped byte not presented on the next beat");

  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(push && pop))
    else $error("push and pop in the same request");

endmodule

// ===== rtl/uart_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered data.
module uart_ram
  import uart_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = UART_FIFO_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
